// File: rtl/ccws_pkg.sv
package ccws_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam int unsigned SECONDS_PER_MINUTE = 60;
    localparam int unsigned MINUTES_PER_HOUR   = 60;
    localparam int unsigned HOURS_PER_DAY      = 24;
    localparam int unsigned MONTHS_PER_YEAR    = 12;
    localparam int unsigned LAST_YEAR          = 99;
    localparam int unsigned MAX_DAY            = 31;

    typedef struct packed {
        logic       operation;
        logic [6:0] set_second;
        logic [6:0] set_minute;
        logic [6:0] set_hour;
        logic [6:0] set_day;
        logic [6:0] set_month;
        logic [6:0] set_year;
    } req_word_t;

    typedef struct packed {
        logic [5:0] cur_second;
        logic [5:0] cur_minute;
        logic [4:0] cur_hour;
        logic [4:0] cur_day;
        logic [3:0] cur_month;
        logic [6:0] cur_year;
        logic       is_leap;
        logic       clock_valid;
        logic       set_rejected;
    } rsp_word_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic       leap_year;
        logic       clock_ok;
    } cal_t;

endpackage

// File: rtl/calendar_clock_with_sync.sv
// calendar clock: second, minute, hour, day, month, two-digit year, leap flag
// request channel (req_valid/req_ready/req_word): each word either ticks the
// clock by one second (operation = tick) or loads all six fields after a
// range check (operation = set); a failed check keeps the old time and clears
// clock_valid
// response channel (rsp_valid/rsp_ready/rsp_word): exactly one word per
// request, the time after that request, in request order
// response path: the accept edge fills the input register, then the result
// register loads once it is free and drives rsp_valid
// throughput: one word per cycle while rsp_ready is high; the combinational
// rollover compare chain into the calendar registers sets that figure
// reset: time 00:00:00, day 1, month 1, year 00 (leap), clock_valid low, both
// pipeline registers empty
// stall: when rsp_ready is low the result register holds, then the input
// register fills and req_ready drops; nothing is lost or repeated
module calendar_clock_with_sync (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ccws_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ccws_pkg::rsp_word_t rsp_word
);
    import ccws_pkg::*;

    logic      in_valid_reg;
    req_word_t in_word_reg;
    logic      out_valid_reg;
    rsp_word_t out_word_reg;
    cal_t      cal_reg;
    cal_t      cal_next;
    logic      rejected;
    logic      out_free;
    logic      advance;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign advance   = in_valid_reg && out_free;
    assign req_ready = !in_valid_reg || out_free;
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    ccws_step u_step (
        .cur      (cal_reg),
        .word     (in_word_reg),
        .nxt      (cal_next),
        .rejected (rejected)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            cal_reg.second    <= 6'd0;
            cal_reg.minute    <= 6'd0;
            cal_reg.hour      <= 5'd0;
            cal_reg.day       <= 5'd1;
            cal_reg.month     <= 4'd1;
            cal_reg.year      <= 7'd0;
            cal_reg.leap_year <= 1'b1;
            cal_reg.clock_ok  <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                cal_reg <= cal_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_word_reg <= req_word;
        end
        if (advance)
        begin
            out_word_reg.cur_second   <= cal_next.second;
            out_word_reg.cur_minute   <= cal_next.minute;
            out_word_reg.cur_hour     <= cal_next.hour;
            out_word_reg.cur_day      <= cal_next.day;
            out_word_reg.cur_month    <= cal_next.month;
            out_word_reg.cur_year     <= cal_next.year;
            out_word_reg.is_leap      <= cal_next.leap_year;
            out_word_reg.clock_valid  <= cal_next.clock_ok;
            out_word_reg.set_rejected <= rejected;
        end
    end

endmodule

// File: rtl/ccws_step.sv
module ccws_step (
    input  ccws_pkg::cal_t      cur,
    input  ccws_pkg::req_word_t word,
    output ccws_pkg::cal_t      nxt,
    output logic                rejected
);
    import ccws_pkg::*;

    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       day_wrap;
    logic       month_wrap;
    logic [5:0] day_inc;
    logic [5:0] month_len;
    logic       set_ok;
    cal_t       ticked;

    always_comb
    begin
        case (cur.month)
            4'd2:    month_len = cur.leap_year ? 6'd29 : 6'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   month_len = 6'd30;
            default: month_len = 6'd31;
        endcase
    end

    assign sec_wrap   = cur.second == 6'(SECONDS_PER_MINUTE - 1);
    assign min_wrap   = sec_wrap && (cur.minute == 6'(MINUTES_PER_HOUR - 1));
    assign hour_wrap  = min_wrap && (cur.hour == 5'(HOURS_PER_DAY - 1));
    assign day_inc    = {1'b0, cur.day} + 6'd1;
    // a day loaded past the month end also rolls at the next carry
    assign day_wrap   = hour_wrap && (day_inc > month_len);
    assign month_wrap = day_wrap && (cur.month >= 4'(MONTHS_PER_YEAR));

    always_comb
    begin
        ticked = cur;
        ticked.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
        if (sec_wrap)
        begin
            ticked.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
        end
        if (min_wrap)
        begin
            ticked.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
        end
        if (hour_wrap)
        begin
            ticked.day = day_wrap ? 5'd1 : day_inc[4:0];
        end
        if (day_wrap)
        begin
            ticked.month = month_wrap ? 4'd1 : cur.month + 4'd1;
        end
        if (month_wrap)
        begin
            ticked.year = (cur.year >= 7'(LAST_YEAR)) ? 7'd0 : cur.year + 7'd1;
            ticked.leap_year = (cur.year >= 7'(LAST_YEAR)) ? 1'b1 : (ticked.year[1:0] == 2'd0);
        end
    end

    assign set_ok = (word.set_second <= 7'(SECONDS_PER_MINUTE - 1))
                 && (word.set_minute <= 7'(MINUTES_PER_HOUR - 1))
                 && (word.set_hour <= 7'(HOURS_PER_DAY - 1))
                 && (word.set_day >= 7'd1) && (word.set_day <= 7'(MAX_DAY))
                 && (word.set_month >= 7'd1) && (word.set_month <= 7'(MONTHS_PER_YEAR))
                 && (word.set_year <= 7'(LAST_YEAR));

    always_comb
    begin
        rejected = 1'b0;
        nxt = ticked;
        if (word.operation == OP_SET)
        begin
            nxt = cur;
            if (set_ok)
            begin
                nxt.second    = word.set_second[5:0];
                nxt.minute    = word.set_minute[5:0];
                nxt.hour      = word.set_hour[4:0];
                nxt.day       = word.set_day[4:0];
                nxt.month     = word.set_month[3:0];
                nxt.year      = word.set_year;
                nxt.leap_year = word.set_year[1:0] == 2'd0;
                nxt.clock_ok  = 1'b1;
            end
            else
            begin
                nxt.clock_ok = 1'b0;
                rejected     = 1'b1;
            end
        end
    end

endmodule
